@@ hdl/rmst_pkg.sv @@
package rmst_pkg;

  // widths fixed by the item formats
  localparam int VALUE_W = 32;
  localparam int FIELD_POS_W = 10;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // request item
  typedef struct packed {
    logic                      op;
    logic [FIELD_POS_W-1:0]    first_pos;
    logic [FIELD_POS_W-1:0]    last_pos;
    logic signed [VALUE_W-1:0] new_value;
  } req_t;

  // response item
  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [FIELD_POS_W-1:0]    max_pos;
    logic                      bad_range;
  } rsp_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLIMB,
    S_WALK,
    S_DRAIN,
    S_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic climb;
    logic walk;
    logic reply_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic climb_last;
    logic walk_more;
    logic req_query;
    logic req_bad;
    logic req_skip;
    logic out_free;
  } status_t;

endpackage

@@ hdl/rmst_ctrl.sv @@
module rmst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rmst_pkg::status_t  st,
  output rmst_pkg::cmd_t     cmd
);

  rmst_pkg::state_t state;
  rmst_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmst_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rmst_pkg::S_CLEAR: begin
        if (st.clear_last) begin
          state_next = rmst_pkg::S_IDLE;
        end
      end
      rmst_pkg::S_IDLE: begin
        if (req_valid) begin
          priority if (!st.req_query) begin
            state_next = st.req_skip ? rmst_pkg::S_IDLE : rmst_pkg::S_CLIMB;
          end else if (st.req_bad) begin
            state_next = rmst_pkg::S_REPLY;
          end else begin
            state_next = rmst_pkg::S_WALK;
          end
        end
      end
      rmst_pkg::S_CLIMB: begin
        if (st.climb_last) begin
          state_next = rmst_pkg::S_IDLE;
        end
      end
      rmst_pkg::S_WALK: begin
        if (!st.walk_more) begin
          state_next = rmst_pkg::S_DRAIN;
        end
      end
      rmst_pkg::S_DRAIN: begin
        state_next = rmst_pkg::S_REPLY;
      end
      rmst_pkg::S_REPLY: begin
        if (st.out_free) begin
          state_next = rmst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rmst_pkg::S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      rmst_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      rmst_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.accept = req_valid;
      end
      rmst_pkg::S_CLIMB: cmd.climb = 1'b1;
      rmst_pkg::S_WALK:  cmd.walk = 1'b1;
      rmst_pkg::S_DRAIN: cmd = '0;
      rmst_pkg::S_REPLY: cmd.reply_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/rmst_datapath.sv @@
module rmst_datapath #(
  parameter int LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  rmst_pkg::req_t     req,
  input  rmst_pkg::cmd_t     cmd,
  output rmst_pkg::status_t  st,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rmst_pkg::rsp_t     rsp
);

  localparam int POS_W  = $clog2(LEAVES);
  localparam int ADDR_W = POS_W + 1;
  localparam int LR_W   = ADDR_W + 1;
  localparam int CW     = (LR_W > rmst_pkg::FIELD_POS_W + 1) ? LR_W
                                                             : rmst_pkg::FIELD_POS_W + 1;
  localparam int PX     = (POS_W > rmst_pkg::FIELD_POS_W) ? POS_W : rmst_pkg::FIELD_POS_W;
  localparam int DEPTH  = 2 * LEAVES;

  typedef struct packed {
    logic signed [rmst_pkg::VALUE_W-1:0] value;
    logic [POS_W-1:0]                    pos;
  } node_t;

  // larger value wins, equal values go to the lower position
  function automatic logic beats(input node_t b, input node_t a);
    beats = (b.value > a.value) || ((b.value == a.value) && (b.pos < a.pos));
  endfunction

  node_t tree_mem [DEPTH];

  logic [ADDR_W-1:0] clr_n;
  logic [POS_W-1:0]  clr_pos;
  logic [POS_W:0]    clr_stride;
  logic [POS_W:0]    clr_sum;

  logic [ADDR_W-1:0] cur_node;
  node_t             cur;
  logic [ADDR_W-1:0] parent;
  node_t             climb_win;

  logic [LR_W-1:0]   l;
  logic [LR_W-1:0]   r;
  logic              l_lt_r;
  logic              rd_a_en;
  logic              rd_b_en;
  logic              rd_a_v;
  logic              rd_b_v;
  node_t             rd_a;
  node_t             rd_b;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [LR_W-1:0]   r_dec;

  node_t             cand;
  node_t             cand_sel;
  logic              cand_v;
  node_t             best;
  logic              have;
  logic              bad;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  node_t             wr_data;

  logic [CW-1:0]     first_w;
  logic [CW-1:0]     last_w;
  logic [CW-1:0]     leaves_w;
  logic [CW-1:0]     last_c;
  logic [ADDR_W-1:0] leaf;
  logic [PX-1:0]     best_pos_x;

  // request decode
  always_comb begin
    first_w  = CW'(req.first_pos);
    last_w   = CW'(req.last_pos);
    leaves_w = CW'(LEAVES);
    last_c   = (last_w >= leaves_w) ? leaves_w - CW'(1) : last_w;
    leaf     = ADDR_W'(first_w + leaves_w);
  end

  assign st.req_query = (req.op == rmst_pkg::OP_QUERY);
  assign st.req_skip  = (first_w >= leaves_w);
  assign st.req_bad   = (first_w > last_w) || (first_w >= leaves_w);

  // clearing sweep: leftmost leaf of each node, level by level
  assign clr_sum = {1'b0, clr_pos} + clr_stride;
  assign st.clear_last = (clr_n == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_n      <= ADDR_W'(1);
      clr_pos    <= '0;
      clr_stride <= (POS_W + 1)'(LEAVES);
    end else if (cmd.clear_step) begin
      clr_n <= clr_n + ADDR_W'(1);
      if (clr_sum == (POS_W + 1)'(LEAVES)) begin
        clr_pos    <= '0;
        clr_stride <= clr_stride >> 1;
      end else begin
        clr_pos <= clr_sum[POS_W-1:0];
      end
    end
  end

  // climb: merge the current node with its sibling into the parent
  always_comb begin
    parent = cur_node >> 1;
    if (cur_node[0]) begin
      climb_win = beats(cur, rd_a) ? cur : rd_a;
    end else begin
      climb_win = beats(rd_a, cur) ? rd_a : cur;
    end
  end
  assign st.climb_last = (parent == ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_node  <= leaf;
      cur.value <= req.new_value;
      cur.pos   <= POS_W'(first_w);
    end else if (cmd.climb) begin
      cur_node <= parent;
      cur      <= climb_win;
    end
  end

  // query walk bounds
  assign l_lt_r  = (l < r);
  assign st.walk_more = l_lt_r;
  assign rd_a_en = cmd.walk && l_lt_r && l[0];
  assign rd_b_en = cmd.walk && l_lt_r && r[0];
  assign r_dec   = r - LR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      l <= LR_W'(first_w + leaves_w);
      r <= LR_W'(last_c + leaves_w + CW'(1));
    end else if (cmd.walk && l_lt_r) begin
      l <= (l + LR_W'(l[0])) >> 1;
      r <= r >> 1;
    end
  end

  // read address selection
  always_comb begin
    priority if (cmd.accept) begin
      addr_a = leaf ^ ADDR_W'(1);
    end else if (cmd.climb) begin
      addr_a = parent ^ ADDR_W'(1);
    end else begin
      addr_a = l[ADDR_W-1:0];
    end
    addr_b = r_dec[ADDR_W-1:0];
  end

  // write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_n;
    wr_data.value = '0;
    wr_data.pos   = clr_pos;
    priority if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.accept && !st.req_query && !st.req_skip) begin
      wr_en         = 1'b1;
      wr_addr       = leaf;
      wr_data.value = req.new_value;
      wr_data.pos   = POS_W'(first_w);
    end else if (cmd.climb) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = climb_win;
    end
  end

  // tree memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_a <= tree_mem[addr_a];
    rd_b <= tree_mem[addr_b];
  end

  // pick the better of the two nodes read at one level
  always_comb begin
    if (rd_a_v && rd_b_v) begin
      cand_sel = beats(rd_b, rd_a) ? rd_b : rd_a;
    end else if (rd_a_v) begin
      cand_sel = rd_a;
    end else begin
      cand_sel = rd_b;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_a_v <= 1'b0;
      rd_b_v <= 1'b0;
      cand_v <= 1'b0;
      have   <= 1'b0;
    end else begin
      rd_a_v <= rd_a_en;
      rd_b_v <= rd_b_en;
      cand_v <= rd_a_v || rd_b_v;
      if (cmd.accept) begin
        have <= 1'b0;
      end else if (cand_v) begin
        have <= 1'b1;
      end
    end
  end

  // running best over the query range
  always_ff @(posedge clk) begin
    cand <= cand_sel;
    if (cand_v && (!have || beats(cand, best))) begin
      best <= cand;
    end
    if (cmd.accept) begin
      bad <= st.req_bad;
    end
  end

  // output register
  assign st.out_free = !rsp_valid || rsp_ready;
  assign best_pos_x  = PX'(best.pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.reply_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_load) begin
      rsp.bad_range <= bad;
      rsp.max_value <= bad ? '0 : best.value;
      rsp.max_pos   <= bad ? '0 : best_pos_x[rmst_pkg::FIELD_POS_W-1:0];
    end
  end

endmodule

@@ hdl/range_max_segment_tree.sv @@
// write item: the leaf is written on acceptance (dropped if past the last leaf),
//   then climbing recomputes the ancestors up to the root before the next item
// query item: the walk reads up to two nodes per tree level, the drain state lets
//   the reads merge, and the result is loaded once the output is free; a bad range
//   goes straight to reply. reset: clearing writes every node with req_ready low
// LEAVES must be a power of two
module range_max_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  rmst_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output rmst_pkg::rsp_t  rsp
);

  rmst_pkg::cmd_t    cmd;
  rmst_pkg::status_t st;

  // sequencer
  rmst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // tree memory and arithmetic
  rmst_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_LEAVES = 1 << rmst_pkg::FIELD_POS_W;
  localparam int RANDOM_ITEMS = 1720;
  localparam int CALM_ITEMS = 200;
  localparam int SQUEEZE_START = 600;
  localparam int SQUEEZE_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP = 40;

  // leaf store and queue of range maxima still owed by the block
  class max_tracker;
    logic signed [rmst_pkg::VALUE_W-1:0] leaf_value [TREE_LEAVES];
    rmst_pkg::rsp_t pending_maxima [$];
    int unsigned failures;

    function new();
      foreach (leaf_value[p]) leaf_value[p] = '0;
      failures = 0;
    endfunction

    // largest value over an inclusive range, ties to the lowest leaf
    function rmst_pkg::rsp_t range_maximum(int unsigned first, int unsigned last);
      rmst_pkg::rsp_t r;
      int unsigned hi;
      logic signed [rmst_pkg::VALUE_W-1:0] best;
      int unsigned best_pos;
      r = '0;
      if (first > last || first >= TREE_LEAVES) begin
        r.bad_range = 1'b1;
        return r;
      end
      hi = (last >= TREE_LEAVES) ? TREE_LEAVES - 1 : last;
      best = leaf_value[first];
      best_pos = first;
      for (int unsigned p = first + 1; p <= hi; p++) begin
        if (leaf_value[p] > best) begin
          best = leaf_value[p];
          best_pos = p;
        end
      end
      r.max_value = best;
      r.max_pos = best_pos[rmst_pkg::FIELD_POS_W-1:0];
      return r;
    endfunction

    // an item taken by the block
    function void note_item(rmst_pkg::req_t item);
      if (item.op == rmst_pkg::OP_WRITE) begin
        if (item.first_pos < TREE_LEAVES) leaf_value[item.first_pos] = item.new_value;
      end else begin
        pending_maxima.push_back(range_maximum(item.first_pos, item.last_pos));
      end
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // a result leaving the block
    function void check_result(rmst_pkg::rsp_t got);
      rmst_pkg::rsp_t want;
      if (pending_maxima.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = pending_maxima.pop_front();
      if (got.max_value !== want.max_value) report("max_value", want.max_value, got.max_value);
      if (got.max_pos !== want.max_pos) report("max_pos", want.max_pos, got.max_pos);
      if (got.bad_range !== want.bad_range) report("bad_range", want.bad_range, got.bad_range);
    endfunction

    function int unsigned owed();
      return pending_maxima.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  rmst_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rmst_pkg::rsp_t rsp;

  max_tracker board = new();
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  range_max_segment_tree #(
    .LEAVES(TREE_LEAVES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // both handshakes sampled before the edge takes effect
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.note_item(req);
      if (rsp_valid && rsp_ready) board.check_result(rsp);
    end
  end

  // result side: random stalls, one long hold on request, none when calm
  initial begin
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // offer one item and wait until the block takes it
  task automatic send_item(input rmst_pkg::req_t item);
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_leaf(input int unsigned pos,
                            input logic [rmst_pkg::VALUE_W-1:0] value,
                            input int unsigned junk_last);
    rmst_pkg::req_t item;
    item.op = rmst_pkg::OP_WRITE;
    item.first_pos = pos[rmst_pkg::FIELD_POS_W-1:0];
    item.last_pos = junk_last[rmst_pkg::FIELD_POS_W-1:0];
    item.new_value = value;
    send_item(item);
    sender_pause();
  endtask

  task automatic query_range(input int unsigned first, input int unsigned last,
                             input logic [rmst_pkg::VALUE_W-1:0] junk_value);
    rmst_pkg::req_t item;
    item.op = rmst_pkg::OP_QUERY;
    item.first_pos = first[rmst_pkg::FIELD_POS_W-1:0];
    item.last_pos = last[rmst_pkg::FIELD_POS_W-1:0];
    item.new_value = junk_value;
    send_item(item);
    sender_pause();
  endtask

  // positions cluster at both ends and the middle so writes and queries meet
  function automatic int unsigned pick_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(TREE_LEAVES - 16, TREE_LEAVES - 1);
      2: return $urandom_range(496, 527);
      default: return $urandom_range(0, TREE_LEAVES - 1);
    endcase
  endfunction

  function automatic logic [rmst_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(rmst_pkg::VALUE_W-1){1'b0}}};
          1: return {1'b0, {(rmst_pkg::VALUE_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic rmst_pkg::req_t random_item(input bit query_only);
    rmst_pkg::req_t item;
    int unsigned first;
    int unsigned last;
    first = pick_pos();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: last = first + $urandom_range(0, 40);
      4, 5: last = $urandom_range(0, TREE_LEAVES - 1);
      6: last = first;
      7: last = TREE_LEAVES - 1;
      8: begin
        first = (first == 0) ? 1 : first;
        last = first - $urandom_range(1, first);
      end
      default: begin
        first = $urandom_range(0, 3);
        last = TREE_LEAVES - 1 - $urandom_range(0, 3);
      end
    endcase
    if (last >= TREE_LEAVES) last = TREE_LEAVES - 1;
    item.op = (query_only || $urandom_range(0, 1) == 1) ? rmst_pkg::OP_QUERY
                                                        : rmst_pkg::OP_WRITE;
    item.first_pos = first[rmst_pkg::FIELD_POS_W-1:0];
    item.last_pos = last[rmst_pkg::FIELD_POS_W-1:0];
    item.new_value = pick_value();
    return item;
  endfunction

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // untouched tree, extreme leaves and inverted ranges
    query_range(0, TREE_LEAVES - 1, '0);
    query_range(TREE_LEAVES - 1, TREE_LEAVES - 1, '1);
    query_range(5, 4, '0);
    query_range(TREE_LEAVES - 1, 0, '0);
    // ties at the top value go to the lower leaf
    write_leaf(700, {1'b0, {(rmst_pkg::VALUE_W-1){1'b1}}}, 0);
    write_leaf(TREE_LEAVES - 1, {1'b0, {(rmst_pkg::VALUE_W-1){1'b1}}}, 0);
    query_range(0, TREE_LEAVES - 1, '0);
    query_range(701, TREE_LEAVES - 1, '0);
    // most negative values and ties among them
    write_leaf(0, {1'b1, {(rmst_pkg::VALUE_W-1){1'b0}}}, 0);
    query_range(0, 0, '0);
    write_leaf(1, {1'b1, {(rmst_pkg::VALUE_W-1){1'b0}}}, 0);
    query_range(0, 1, '0);
    write_leaf(2, '1, 0);
    query_range(0, 2, '0);
    // overwrite a leaf, maximum moves elsewhere
    write_leaf(700, {1'b1, {(rmst_pkg::VALUE_W-1){1'b0}}}, 0);
    query_range(0, TREE_LEAVES - 1, '0);
    // equal values on both sides of the middle split
    write_leaf(512, 5, 0);
    write_leaf(511, 5, 0);
    query_range(500, 520, '0);
    query_range(0, TREE_LEAVES - 2, '0);
    // unused fields carry junk
    write_leaf(3, 7, TREE_LEAVES - 1);
    query_range(3, 3, '1);

    // random mix, with a long receiver hold while queries keep coming
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i == SQUEEZE_START) hold_off_req = 1'b1;
      send_item(random_item(i >= SQUEEZE_START && i < SQUEEZE_START + SQUEEZE_ITEMS));
      if (i < SQUEEZE_START || i >= SQUEEZE_START + SQUEEZE_ITEMS) sender_pause();
    end
    req_valid <= 1'b0;

    // drain
    while (board.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rmst_pkg.sv
hdl/rmst_ctrl.sv
hdl/rmst_datapath.sv
hdl/range_max_segment_tree.sv
dv/tb_top.sv
